[src/pts_pkg.sv]
package pts_pkg;

   // Item kinds carried on req_kind; codes 5 to 7 are ignored.
   typedef enum logic [2:0] {
      KIND_TICK    = 3'd0,
      KIND_CREATE  = 3'd1,
      KIND_SUSPEND = 3'd2,
      KIND_RESUME  = 3'd3,
      KIND_DELETE  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } fsm_type;

   localparam int PERIOD_W    = 16;
   localparam int DELAY_W     = 8;
   localparam int SLOT_W      = 3;
   // Most fired beats one tick may report.
   localparam int MAX_RESULTS = 8;

   // One task slot as it travels along the cell row.
   typedef struct packed {
      logic                occupied;
      logic                running;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] countdown;
   } slot_rec_type;

   // Operation applied to the slot at the head of the row.
   typedef struct packed {
      logic [2:0]          kind;
      logic                hit;
      logic [PERIOD_W-1:0] period;
      logic [DELAY_W-1:0]  first_delay;
   } slot_op_type;

endpackage

[src/pts_cell.sv]
module pts_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  pts_pkg::slot_rec_type rec_src,
   output pts_pkg::slot_rec_type rec_out
);

   pts_pkg::slot_rec_type rec_ff;
   pts_pkg::slot_rec_type rec_in;

   // Take the neighbor's record on a shift, otherwise hold.
   assign rec_in = shift_en ? rec_src : rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign rec_out = rec_ff;

endmodule

[src/pts_slot_unit.sv]
module pts_slot_unit (
   input  pts_pkg::slot_rec_type rec_in,
   input  pts_pkg::slot_op_type  op,
   output pts_pkg::slot_rec_type rec_out,
   output logic                  fire
);

   always_comb begin
      rec_out = rec_in;
      fire    = 1'b0;
      unique case (op.kind)
         pts_pkg::KIND_TICK: begin
            if (rec_in.running) begin
               if (rec_in.countdown != '0) begin
                  rec_out.countdown = rec_in.countdown - 16'd1;
               end else if (rec_in.occupied) begin
                  fire              = 1'b1;
                  rec_out.countdown = (rec_in.period == '0) ? '0 : rec_in.period - 16'd1;
               end
            end
         end
         pts_pkg::KIND_CREATE: begin
            if (op.hit && !rec_in.occupied) begin
               rec_out.occupied  = 1'b1;
               rec_out.running   = 1'b1;
               rec_out.period    = op.period;
               rec_out.countdown = {{(pts_pkg::PERIOD_W-pts_pkg::DELAY_W){1'b0}},
                                    op.first_delay};
            end
         end
         pts_pkg::KIND_SUSPEND: begin
            if (op.hit) begin
               rec_out.running = 1'b0;
            end
         end
         pts_pkg::KIND_RESUME: begin
            if (op.hit) begin
               rec_out.running = 1'b1;
            end
         end
         pts_pkg::KIND_DELETE: begin
            if (op.hit) begin
               rec_out.occupied = 1'b0;
            end
         end
         default: begin
            rec_out = rec_in;
         end
      endcase
   end

endmodule

[src/periodic_task_tick_scheduler.sv]
// Every item walks all NUM_SLOTS slots from acceptance to its final result beat; a tick's
// fired beats come out during that walk, lowest slot first. All records rotate once through
// the single update unit at the head of the row, one slot per cycle while the result register
// is free, so one item is in work at a time.
// Synchronous active-high reset clears every slot (not occupied, not running, zero period
// and countdown), empties the result register and returns the sequencer to idle.
module periodic_task_tick_scheduler #(
   parameter int NUM_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_period,
   input  logic [7:0]  req_first_delay,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_fired,
   output logic [2:0]  rsp_fired_slot,
   output logic        rsp_last
);

   // Index width of the slot walk; keep at least one bit for a single slot.
   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   // Common width for comparing the walk index against the slot field.
   localparam int CW = (IW > pts_pkg::SLOT_W) ? IW : pts_pkg::SLOT_W;
   // Firings reported per tick; later due slots still reload but stay silent.
   localparam logic [3:0] FIRE_CAP = 4'(pts_pkg::MAX_RESULTS);

   pts_pkg::fsm_type      state_ff, state_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [2:0]            kind_ff, kind_in;
   logic [2:0]            slot_ff, slot_in;
   logic [15:0]           period_ff, period_in;
   logic [7:0]            delay_ff, delay_in;
   logic [3:0]            fire_cnt_ff, fire_cnt_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [2:0]            pend_slot_ff, pend_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_fired_ff, rsp_fired_in;
   logic [2:0]            rsp_fired_slot_ff, rsp_fired_slot_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  shift_en;
   logic                  out_free;
   logic [CW-1:0]         idx_cw;
   logic [CW-1:0]         slot_cw;
   pts_pkg::slot_op_type  op;
   pts_pkg::slot_rec_type rec_q [NUM_SLOTS];
   pts_pkg::slot_rec_type head_new;
   logic                  head_fire;

   // The slot row: cell k takes from cell k+1, the last cell takes the updated head.
   // After j shifts slot j sits in cell 0; after NUM_SLOTS shifts every slot is home.
   for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
      if (k == NUM_SLOTS - 1) begin : g_tail
         pts_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .rec_src  (head_new),
            .rec_out  (rec_q[k])
         );
      end else begin : g_body
         pts_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .rec_src  (rec_q[k+1]),
            .rec_out  (rec_q[k])
         );
      end
   end

   assign idx_cw  = CW'(idx_ff);
   assign slot_cw = CW'(slot_ff);

   // Edit commands hit only the slot they name; an out-of-range slot never matches.
   always_comb begin
      op.kind        = kind_ff;
      op.hit         = (kind_ff != pts_pkg::KIND_TICK) && (idx_cw == slot_cw);
      op.period      = period_ff;
      op.first_delay = delay_ff;
   end

   pts_slot_unit u_unit (
      .rec_in  (rec_q[0]),
      .op      (op),
      .rec_out (head_new),
      .fire    (head_fire)
   );

   // The result register may be loaded when empty or when its beat leaves now.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in          = state_ff;
      idx_in            = idx_ff;
      kind_in           = kind_ff;
      slot_in           = slot_ff;
      period_in         = period_ff;
      delay_in          = delay_ff;
      fire_cnt_in       = fire_cnt_ff;
      pend_valid_in     = pend_valid_ff;
      pend_slot_in      = pend_slot_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_fired_in      = rsp_fired_ff;
      rsp_fired_slot_in = rsp_fired_slot_ff;
      rsp_last_in       = rsp_last_ff;
      shift_en          = 1'b0;
      req_ready         = 1'b0;
      unique case (state_ff)
         pts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // Capture the item and start the walk at slot 0.
               kind_in       = req_kind;
               slot_in       = req_slot;
               period_in     = req_period;
               delay_in      = req_first_delay;
               idx_in        = '0;
               fire_cnt_in   = '0;
               pend_valid_in = 1'b0;
               state_in      = pts_pkg::ST_SCAN;
            end
         end
         pts_pkg::ST_SCAN: begin
            // Advance one slot per cycle; hold while a beat is stuck at the output.
            if (out_free) begin
               shift_en = 1'b1;
               if (head_fire && (fire_cnt_ff < FIRE_CAP)) begin
                  // A new firing means the held one is not the last: send it on.
                  if (pend_valid_ff) begin
                     rsp_valid_in      = 1'b1;
                     rsp_fired_in      = 1'b1;
                     rsp_fired_slot_in = pend_slot_ff;
                     rsp_last_in       = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = idx_cw[2:0];
                  fire_cnt_in   = fire_cnt_ff + 4'd1;
               end
               if (idx_ff == IW'(NUM_SLOTS - 1)) begin
                  state_in = pts_pkg::ST_FLUSH;
               end else begin
                  idx_in = IW'(idx_ff + 1'b1);
               end
            end
         end
         pts_pkg::ST_FLUSH: begin
            // Close the item: the held firing, or one empty beat, marked last.
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_fired_in      = pend_valid_ff;
               rsp_fired_slot_in = pend_valid_ff ? pend_slot_ff : 3'd0;
               rsp_last_in       = 1'b1;
               state_in          = pts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pts_pkg::ST_IDLE;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff           <= kind_in;
      slot_ff           <= slot_in;
      period_ff         <= period_in;
      delay_ff          <= delay_in;
      fire_cnt_ff       <= fire_cnt_in;
      pend_slot_ff      <= pend_slot_in;
      rsp_fired_ff      <= rsp_fired_in;
      rsp_fired_slot_ff <= rsp_fired_slot_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_fired_slot = rsp_fired_slot_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

[src/pts_checker.sv]
module pts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_fired,
   input logic [2:0] rsp_fired_slot,
   input logic       rsp_last
);

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present right after reset");

   // An empty beat always closes its item.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_last)
      else $error("empty result beat not marked last");

   // An empty beat carries slot zero.
   a_empty_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_fired_slot == 3'd0)
      else $error("empty result beat with nonzero slot");

   // The block is busy walking the slots right after taking an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken again before the slot walk");

   // A stalled beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired_slot)
      && $stable(rsp_fired) && $stable(rsp_last))
      else $error("stalled result beat changed");

endmodule

bind periodic_task_tick_scheduler pts_checker u_pts_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_fired      (rsp_fired),
   .rsp_fired_slot (rsp_fired_slot),
   .rsp_last       (rsp_last)
);
